>>> hdl/sic_pkg.sv
// shared types and constants for the streaming inversion counter
package sic_pkg;

  localparam int unsigned ValueWidth      = 32;
  localparam int unsigned NewPairsWidth   = 8;
  localparam int unsigned TotalPairsWidth = 15;

  localparam logic [NewPairsWidth-1:0]   NEW_PAIRS_MAX = 8'hFF;
  localparam logic [TotalPairsWidth-1:0] TOTAL_MAX     = 15'h7FFF;

  // control and payload of the token walking the cell chain
  typedef struct packed {
    logic                         valid;
    logic signed [ValueWidth-1:0] value;
    logic                         last;
    logic                         full;
    logic                         placed;
  } sic_token_t;

endpackage

>>> hdl/sic_in_if.sv
// input channel: one sequence element per transaction
interface sic_in_if;
  import sic_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [ValueWidth-1:0] value;
  logic                         seq_last;

  modport source (output valid, output value, output seq_last, input ready);
  modport sink (input valid, input value, input seq_last, output ready);
endinterface

>>> hdl/sic_out_if.sv
// output channel: one count result per transaction
interface sic_out_if;
  import sic_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [NewPairsWidth-1:0]   new_pairs;
  logic [TotalPairsWidth-1:0] total_pairs;
  logic                       capacity_exceeded;
  logic                       out_last;

  modport source (
    output valid, output new_pairs, output total_pairs,
    output capacity_exceeded, output out_last, input ready
  );
  modport sink (
    input valid, input new_pairs, input total_pairs,
    input capacity_exceeded, input out_last, output ready
  );
endinterface

>>> hdl/sic_cell.sv
// one chain cell: holds a stored value, compares or stores the passing token
module sic_cell
  import sic_pkg::*;
#(
  parameter int unsigned RemWidth = 8,
  parameter int unsigned GtWidth  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  sic_token_t          tok_i,
  input  logic [RemWidth-1:0] rem_i,
  input  logic [GtWidth-1:0]  gt_i,
  output sic_token_t          tok_o,
  output logic [RemWidth-1:0] rem_o,
  output logic [GtWidth-1:0]  gt_o
);

  logic signed [ValueWidth-1:0] stored_q;
  logic                         valid_q;
  sic_token_t                   tok_d;
  sic_token_t                   tok_q;
  logic [RemWidth-1:0]          rem_d;
  logic [RemWidth-1:0]          rem_q;
  logic [GtWidth-1:0]           gt_d;
  logic [GtWidth-1:0]           gt_q;
  logic                         active;
  logic                         store_here;

  assign active     = tok_i.valid && !tok_i.full && !tok_i.placed;
  assign store_here = active && (rem_i == '0);

  always_comb begin
    tok_d = tok_i;
    rem_d = rem_i;
    gt_d  = gt_i;
    if (store_here) begin
      tok_d.placed = 1'b1;
    end else if (active) begin
      rem_d = rem_i - RemWidth'(1);
      gt_d  = gt_i + GtWidth'(stored_q > tok_i.value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
      rem_q <= rem_d;
      gt_q  <= gt_d;
      if (store_here) begin
        stored_q <= tok_i.value;
      end
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

  assign rem_o = rem_q;
  assign gt_o  = gt_q;

endmodule

>>> hdl/sic_tail.sv
// chain tail: running total, saturation and output register
module sic_tail
  import sic_pkg::*;
#(
  parameter int unsigned GtWidth = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sic_token_t         tok_i,
  input  logic [GtWidth-1:0] gt_i,
  output logic               adv_o,
  sic_out_if.source          out_ch
);

  localparam int unsigned ExtWidth = (GtWidth > NewPairsWidth) ? GtWidth : NewPairsWidth;
  localparam int unsigned SumWidth =
    ((GtWidth > TotalPairsWidth) ? GtWidth : TotalPairsWidth) + 1;

  logic                       out_valid_q;
  logic [NewPairsWidth-1:0]   new_pairs_q;
  logic [TotalPairsWidth-1:0] total_out_q;
  logic                       full_q;
  logic                       last_q;
  logic [TotalPairsWidth-1:0] total_d;
  logic [TotalPairsWidth-1:0] total_q;
  logic [ExtWidth-1:0]        gt_ext;
  logic [SumWidth-1:0]        sum;
  logic [NewPairsWidth-1:0]   new_pairs_d;
  logic [TotalPairsWidth-1:0] total_new;

  assign adv_o  = !out_valid_q || out_ch.ready;
  assign gt_ext = ExtWidth'(gt_i);
  assign sum    = SumWidth'(total_q) + SumWidth'(gt_i);

  always_comb begin
    if (tok_i.full) begin
      new_pairs_d = '0;
      total_new   = total_q;
    end else begin
      new_pairs_d = (gt_ext > ExtWidth'(NEW_PAIRS_MAX)) ? NEW_PAIRS_MAX
                                                        : gt_ext[NewPairsWidth-1:0];
      total_new   = (sum > SumWidth'(TOTAL_MAX)) ? TOTAL_MAX
                                                 : sum[TotalPairsWidth-1:0];
    end
    total_d = total_q;
    if (adv_o && tok_i.valid) begin
      total_d = tok_i.last ? '0 : total_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      total_q <= total_d;
      if (adv_o) begin
        out_valid_q <= tok_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && tok_i.valid) begin
      new_pairs_q <= new_pairs_d;
      total_out_q <= total_new;
      full_q      <= tok_i.full;
      last_q      <= tok_i.last;
    end
  end

  assign out_ch.valid             = out_valid_q;
  assign out_ch.new_pairs         = new_pairs_q;
  assign out_ch.total_pairs       = total_out_q;
  assign out_ch.capacity_exceeded = full_q;
  assign out_ch.out_last          = last_q;

endmodule

>>> hdl/streaming_inversion_counter_unit.sv
// top level of the streaming inversion counter
//
// in_ch carries one signed 32-bit element per transaction, seq_last marks
// the final element of a sequence. out_ch returns one result per element:
// how many earlier stored elements are strictly greater, the running total
// of inversions, a flag when the store of MAX_ELEMENTS entries was full and
// the element was dropped, and out_last copied from seq_last.
// each element becomes a token that walks a chain of MAX_ELEMENTS cells, one
// cell per cycle unless stalled; occupied cells add their compare to the
// token and the first free cell keeps the element. out_ch.valid rises after
// the cell registers and the tail's output register. throughput is one
// element per cycle unless stalled, since a token only meets cells written
// by tokens ahead of it. reset empties the store and clears the running
// total; no clearing pass. when the receiver stalls, the output register
// holds and the whole chain freezes, so in_ch.ready drops in the same cycle.
module streaming_inversion_counter_unit
  import sic_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sic_in_if.sink    in_ch,
  sic_out_if.source out_ch
);

  localparam int unsigned CntWidth = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned RemWidth = $clog2(MAX_ELEMENTS);
  localparam int unsigned GtWidth  = $clog2(MAX_ELEMENTS);

  logic                adv;
  logic                accept;
  logic                full;
  logic [CntWidth-1:0] count_d;
  logic [CntWidth-1:0] count_q;

  sic_token_t          tok   [MAX_ELEMENTS+1];
  logic [RemWidth-1:0] rem   [MAX_ELEMENTS+1];
  logic [GtWidth-1:0]  gt    [MAX_ELEMENTS+1];

  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;
  assign full        = (count_q == CntWidth'(MAX_ELEMENTS));

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (in_ch.seq_last) begin
        count_d = '0;
      end else if (!full) begin
        count_d = count_q + CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    tok[0].valid  = accept;
    tok[0].value  = in_ch.value;
    tok[0].last   = in_ch.seq_last;
    tok[0].full   = full;
    tok[0].placed = 1'b0;
    rem[0]        = count_q[RemWidth-1:0];
    gt[0]         = '0;
  end

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    sic_cell #(
      .RemWidth(RemWidth),
      .GtWidth (GtWidth)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (tok[i]),
      .rem_i (rem[i]),
      .gt_i  (gt[i]),
      .tok_o (tok[i+1]),
      .rem_o (rem[i+1]),
      .gt_o  (gt[i+1])
    );
  end

  sic_tail #(
    .GtWidth(GtWidth)
  ) u_tail (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (tok[MAX_ELEMENTS]),
    .gt_i  (gt[MAX_ELEMENTS]),
    .adv_o (adv),
    .out_ch(out_ch)
  );

endmodule
